>>> rtl/frcd_pkg.sv
// Shared constants and types for the framed ratio command decoder.
// No dependencies.
`timescale 1ns / 1ps
package frcd_pkg;
  localparam logic [1:0] KIND_GET  = 2'd0;
  localparam logic [1:0] KIND_HELP = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] small_pct;
    logic [6:0] large_pct;
  } frcd_result_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h3D) || (c == 8'h3A) || (c == 8'h2C);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
  endfunction
endpackage

>>> rtl/frcd_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module frcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/frcd_parser.sv
// Byte-serial packet parser: walks stored text one character at a time.
// Depends on frcd_pkg.
`timescale 1ns / 1ps
module frcd_parser import frcd_pkg::*; #(
  parameter int PACKET_BYTES = 64,
  parameter int WORD_BYTES   = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [$clog2(PACKET_BYTES)-1:0] text_len,
  output logic [$clog2(PACKET_BYTES)-1:0] raddr,
  input  logic [7:0]                      rdata,
  output logic                            done,
  output frcd_result_t                    result
);
  localparam int AW = $clog2(PACKET_BYTES);
  localparam int WW = $clog2(WORD_BYTES + 1);

  // phases
  localparam logic [3:0] P_IDLE   = 4'd0;
  localparam logic [3:0] P_FETCH  = 4'd1;
  localparam logic [3:0] P_LEAD   = 4'd2;
  localparam logic [3:0] P_WORD   = 4'd3;
  localparam logic [3:0] P_SEP    = 4'd4;
  localparam logic [3:0] P_SIGN   = 4'd5;
  localparam logic [3:0] P_INT    = 4'd6;
  localparam logic [3:0] P_FRAC   = 4'd7;
  localparam logic [3:0] P_TAIL   = 4'd8;
  localparam logic [3:0] P_DONE   = 4'd9;

  logic [3:0]    phase, ret_phase;
  logic [AW:0]   pos, len;
  logic [WW-1:0] wlen;
  logic [7:0]    w0, w1, w2, w3, w4;
  logic          neg, second, any;
  logic [6:0]    mag, frac, a_pct;
  logic [1:0]    fdig;
  frcd_result_t  res;

  logic [7:0] c;
  assign c = (pos < len) ? rdata : 8'd0;
  assign raddr = pos[AW-1:0];
  assign done = (phase == P_DONE);
  assign result = res;

  logic [7:0] u0, u1, u2, u3, u4;
  assign u0 = to_upper(w0);
  assign u1 = to_upper(w1);
  assign u2 = to_upper(w2);
  assign u3 = to_upper(w3);
  assign u4 = to_upper(w4);

  logic is_get, is_help, is_set;
  always_comb begin
    is_get  = (wlen == WW'(3) && u0 == 8'h47 && u1 == 8'h45 && u2 == 8'h54) ||
              (wlen == WW'(1) && w0 == 8'h3F);
    is_help = wlen == WW'(4) && u0 == 8'h48 && u1 == 8'h45 && u2 == 8'h4C && u3 == 8'h50;
    is_set  = (wlen == WW'(3) && u0 == 8'h53 && u1 == 8'h45 && u2 == 8'h54) ||
              (wlen == WW'(5) && u0 == 8'h50 && u1 == 8'h41 && u2 == 8'h52 &&
               u3 == 8'h41 && u4 == 8'h4D) ||
              (wlen == WW'(4) && u0 == 8'h44 && u1 == 8'h49 && u2 == 8'h46 && u3 == 8'h46);
  end

  logic [10:0] mag_x10;
  logic [6:0]  mag_step;
  assign mag_x10  = 11'(mag) * 11'd10 + 11'(c - 8'h30);
  assign mag_step = (mag_x10 > 11'd101) ? 7'd101 : mag_x10[6:0];

  logic [6:0] val_frac;
  assign val_frac = (fdig == 2'd1) ? 7'(frac * 7'd10) : frac;

  // finish one ratio; ok/value in pct_ok, pct_val
  logic       pct_ok;
  logic [6:0] pct_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      case (phase)
        P_IDLE: begin
          if (start) begin
            len <= (AW+1)'(text_len);
            pos <= '0;
            wlen <= '0;
            second <= 1'b0;
            res <= '{kind: KIND_ERR, small_pct: 7'd0, large_pct: 7'd0};
            ret_phase <= P_LEAD;
            phase <= P_FETCH;
          end
        end
        P_FETCH: phase <= ret_phase;  // RAM read latency
        P_LEAD: begin
          if (is_sep(c)) begin
            pos <= pos + 1'b1; ret_phase <= P_LEAD; phase <= P_FETCH;
          end else begin
            ret_phase <= P_WORD; phase <= P_WORD;
          end
        end
        P_WORD: begin
          if (c != 8'd0 && !is_sep(c)) begin
            if (32'(wlen) + 1 >= WORD_BYTES) begin
              phase <= P_DONE;
            end else begin
              case (wlen)
                WW'(0): w0 <= c;
                WW'(1): w1 <= c;
                WW'(2): w2 <= c;
                WW'(3): w3 <= c;
                WW'(4): w4 <= c;
                default: ;
              endcase
              wlen <= wlen + 1'b1;
              pos <= pos + 1'b1; ret_phase <= P_WORD; phase <= P_FETCH;
            end
          end else if (wlen == '0) begin
            phase <= P_DONE;
          end else if (is_get) begin
            res.kind <= KIND_GET; phase <= P_DONE;
          end else if (is_help) begin
            res.kind <= KIND_HELP; phase <= P_DONE;
          end else if (is_set) begin
            phase <= P_SEP;
          end else begin
            phase <= P_DONE;
          end
        end
        P_SEP: begin
          neg <= 1'b0; any <= 1'b0; mag <= '0; frac <= '0; fdig <= '0;
          if (is_sep(c)) begin
            pos <= pos + 1'b1; ret_phase <= P_SEP; phase <= P_FETCH;
          end else begin
            phase <= P_SIGN;
          end
        end
        P_SIGN: begin
          if (c == 8'h2D || c == 8'h2B) begin
            neg <= (c == 8'h2D);
            pos <= pos + 1'b1; ret_phase <= P_INT; phase <= P_FETCH;
          end else begin
            phase <= P_INT;
          end
        end
        P_INT: begin
          if (is_dig(c)) begin
            mag <= mag_step; any <= 1'b1;
            pos <= pos + 1'b1; ret_phase <= P_INT; phase <= P_FETCH;
          end else if (!any || (neg && mag != '0)) begin
            phase <= P_DONE;
          end else if (c == 8'h2E) begin
            pos <= pos + 1'b1; ret_phase <= P_FRAC; phase <= P_FETCH;
          end else if (pct_ok) begin
            if (second) begin
              res.large_pct <= pct_val; phase <= P_TAIL;
            end else begin
              a_pct <= pct_val; second <= 1'b1; phase <= P_SEP;
            end
          end else begin
            phase <= P_DONE;
          end
        end
        P_FRAC: begin
          if (is_dig(c) && fdig != 2'd2) begin
            frac <= 7'(frac * 7'd10 + 7'(c - 8'h30)); fdig <= fdig + 1'b1;
            pos <= pos + 1'b1; ret_phase <= P_FRAC; phase <= P_FETCH;
          end else if (fdig == '0 || is_dig(c) || mag > 7'd1 ||
                       (mag == 7'd1 && val_frac != '0)) begin
            phase <= P_DONE;
          end else if (second) begin
            res.large_pct <= pct_val; phase <= P_TAIL;
          end else begin
            a_pct <= pct_val; second <= 1'b1; phase <= P_SEP;
          end
        end
        P_TAIL: begin
          if (is_sep(c)) begin
            pos <= pos + 1'b1; ret_phase <= P_TAIL; phase <= P_FETCH;
          end else begin
            if (c == 8'd0) begin
              res.kind <= KIND_SET; res.small_pct <= a_pct;
            end else begin
              res.large_pct <= '0;
            end
            phase <= P_DONE;
          end
        end
        P_DONE: phase <= P_IDLE;
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_comb begin
    if (phase == P_FRAC) begin
      pct_val = (mag == 7'd1) ? 7'd100 : val_frac;
      pct_ok  = 1'b1;
    end else begin
      pct_val = mag;
      pct_ok  = mag <= 7'd100;
    end
  end
endmodule

>>> rtl/framed_ratio_command_decoder_core.sv
// Top level of the framed ratio command decoder: framing, text store, parser.
// Depends on frcd_pkg, frcd_ram, frcd_parser.
//
// channel  dir  tdata fields (low bit first)
// s_axis   in   rx_byte[7:0]
// m_axis   out  command_kind[1:0], small_percent[8:2], large_percent[15:9]
//
// Packet bytes are written to the text store as they are accepted. On '}' the parser walks
// the text over the single RAM read port, fetching each character it visits before examining
// it, and m_axis_tvalid rises once it finishes.
// The block takes no word while parsing or while a result waits.
// rst is synchronous; text store contents are not cleared.
`timescale 1ns / 1ps
module framed_ratio_command_decoder_core import frcd_pkg::*; #(
  parameter int PACKET_BYTES = 64,
  parameter int WORD_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // command_kind, small_percent, large_percent
);
  localparam int AW = $clog2(PACKET_BYTES);

  logic          in_packet, busy;
  logic [AW-1:0] fill_count, raddr;
  logic [7:0]    rdata;
  logic          start, pdone;
  frcd_result_t  pres;

  logic acc;
  assign s_axis_tready = !busy && !m_axis_tvalid;
  assign acc = s_axis_tvalid && s_axis_tready;

  logic wr;
  assign wr = acc && in_packet && s_axis_tdata != CH_OPEN && s_axis_tdata != CH_CLOSE &&
              32'(fill_count) < PACKET_BYTES - 1;
  assign start = acc && in_packet && s_axis_tdata == CH_CLOSE;

  frcd_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_ram (
    .clk(clk), .we(wr), .waddr(fill_count), .wdata(s_axis_tdata),
    .raddr(raddr), .rdata(rdata)
  );

  frcd_parser #(.PACKET_BYTES(PACKET_BYTES), .WORD_BYTES(WORD_BYTES)) u_parser (
    .clk(clk), .rst(rst), .start(start), .text_len(fill_count),
    .raddr(raddr), .rdata(rdata), .done(pdone), .result(pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
      fill_count <= '0;
      busy <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (acc) begin
        if (s_axis_tdata == CH_OPEN) begin
          in_packet <= 1'b1; fill_count <= '0;
        end else if (in_packet) begin
          if (s_axis_tdata == CH_CLOSE) begin
            in_packet <= 1'b0; fill_count <= '0; busy <= 1'b1;
          end else if (wr) begin
            fill_count <= fill_count + 1'b1;
          end else begin
            in_packet <= 1'b0; fill_count <= '0;  // drop overlong packet
          end
        end
      end
      if (pdone) begin
        busy <= 1'b0;
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {pres.large_pct, pres.small_pct, pres.kind};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("input taken while parsing");
  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    pdone |-> busy) else $error("parser finished while idle");
  a_fill_zero_out: assert property (@(posedge clk) disable iff (rst)
    !in_packet |-> fill_count == '0) else $error("fill count without packet");
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == KIND_SET) |->
      (m_axis_tdata[8:2] <= 7'd100 && m_axis_tdata[15:9] <= 7'd100))
    else $error("percent out of range");
endmodule
